[rtl/core/lcf_pkg.sv]
// ----------------------------------------------------------------------------
// lcf_pkg
// Shared types and constants of the linear convolution FIR block.
// ----------------------------------------------------------------------------
package lcf_pkg;

  localparam int RES_W = 36;   // width of one result
  localparam int IDX_W = 4;    // width of a coefficient index
  localparam int CNT_W = 5;    // width of the tap count register

  localparam logic [CNT_W-1:0] TAP_COUNT_RST = 5'd16;

  // Operation codes of an input transaction.
  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // Control part of one queued command; the sample or coefficient travels alongside.
  typedef struct packed {
    logic             is_load;
    logic [IDX_W-1:0] idx;
    logic             last;
  } lcf_entry_t;

endpackage

[rtl/core/lcf_ram.sv]
// ----------------------------------------------------------------------------
// lcf_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module lcf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/lcf_front.sv]
// ----------------------------------------------------------------------------
// lcf_front
// Accepts input transactions, drops coefficient loads aimed beyond the
// coefficient store and queues everything else in order for the back end.
// ----------------------------------------------------------------------------
module lcf_front import lcf_pkg::*; #(
  parameter int TAPS         = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [IDX_W-1:0]        in_coef_index,
  input  logic [SAMPLE_WIDTH-1:0] in_value,
  input  logic                    in_last,
  output logic                    q_valid,
  input  logic                    q_pop,
  output lcf_entry_t              q_entry,
  output logic [SAMPLE_WIDTH-1:0] q_value
);

  localparam int QDEPTH = 2;
  localparam int QCW    = 2;

  lcf_entry_t              ent_r [QDEPTH];
  logic [SAMPLE_WIDTH-1:0] val_r [QDEPTH];
  logic                    wr_ptr_r;
  logic                    rd_ptr_r;
  logic [QCW-1:0]          count_r;
  logic                    keep;
  logic                    push;
  lcf_entry_t              new_entry;

  assign in_stall = (count_r == QCW'(QDEPTH));
  assign keep     = (in_op == OP_SAMPLE) || (32'(in_coef_index) < TAPS);
  assign push     = in_valid && !in_stall && keep;

  always_comb begin
    new_entry.is_load = (in_op == OP_LOAD);
    new_entry.idx     = in_coef_index;
    new_entry.last    = in_last;
  end

  assign q_valid = (count_r != '0);
  assign q_entry = ent_r[rd_ptr_r];
  assign q_value = val_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) begin
        ent_r[wr_ptr_r] <= new_entry;
        val_r[wr_ptr_r] <= in_value;
        wr_ptr_r        <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + QCW'(push) - QCW'(q_pop);
    end
  end

endmodule

[rtl/core/lcf_back.sv]
// ----------------------------------------------------------------------------
// lcf_back
// Executes queued commands: writes coefficients, and for each output position
// runs one multiply-accumulate per tap over the coefficient and delay RAMs.
// ----------------------------------------------------------------------------
module lcf_back import lcf_pkg::*; #(
  parameter int TAPS         = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [CNT_W-1:0]        tap_count,
  input  logic                    q_valid,
  output logic                    q_pop,
  input  lcf_entry_t              q_entry,
  input  logic [SAMPLE_WIDTH-1:0] q_value,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RES_W-1:0]        out_result,
  output logic                    out_final_res
);

  localparam int AW  = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int TCW = $clog2(TAPS + 1);
  localparam int PW  = 2 * SAMPLE_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                         state_r;
  logic [AW-1:0]                  j_r;
  logic [AW-1:0]                  dp_r;
  logic [AW-1:0]                  wp_r;
  logic [TCW-1:0]                 tail_left_r;
  logic                           last_r;
  logic signed [SAMPLE_WIDTH-1:0] x_r;
  logic [TAPS-1:0]                dval_r;
  logic                           s1_vld_r;
  logic                           s1_first_r;
  logic                           s1_last_r;
  logic                           s1_dval_r;
  logic                           s2_vld_r;
  logic                           s2_first_r;
  logic                           s2_last_r;
  logic signed [PW-1:0]           s2_prod_r;
  logic                           done_r;
  logic signed [RES_W-1:0]        acc_r;
  logic                           out_valid_r;
  logic [RES_W-1:0]               out_result_r;
  logic                           out_final_r;

  logic [TCW-1:0]                 tc;
  logic [TCW-1:0]                 tc_m1;
  logic                           coef_we;
  logic                           dly_we;
  logic [AW-1:0]                  dly_raddr;
  logic [SAMPLE_WIDTH-1:0]        coef_rdata;
  logic [SAMPLE_WIDTH-1:0]        dly_rdata;
  logic signed [SAMPLE_WIDTH-1:0] coef_s;
  logic signed [SAMPLE_WIDTH-1:0] h_s;
  logic signed [PW-1:0]           prod;
  logic                           slot_free;
  logic                           final_now;
  logic                           emit;

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? AW'(TAPS - 1) : p - AW'(1);
  endfunction

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == AW'(TAPS - 1)) ? '0 : p + AW'(1);
  endfunction

  // A tap count of zero behaves as one, anything above TAPS as TAPS.
  always_comb begin
    priority if (tap_count == '0) begin
      tc = TCW'(1);
    end else if (32'(tap_count) > TAPS) begin
      tc = TCW'(TAPS);
    end else begin
      tc = TCW'(tap_count);
    end
  end

  assign tc_m1     = tc - TCW'(1);
  assign q_pop     = (state_r == ST_IDLE) && q_valid;
  assign coef_we   = q_pop && q_entry.is_load;
  assign dly_we    = (state_r == ST_DRAIN) && done_r;
  assign dly_raddr = ptr_dec(dp_r);
  assign slot_free = !out_valid_r || !out_stall;
  assign final_now = last_r && (tail_left_r == '0);
  assign emit      = (state_r == ST_EMIT) && slot_free;

  lcf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TAPS)
  ) u_coef_ram (
    .clk   (clk),
    .we    (coef_we),
    .waddr (AW'(q_entry.idx)),
    .wdata (q_value),
    .raddr (j_r),
    .rdata (coef_rdata)
  );

  // Circular history of past samples; an entry without its valid bit reads as zero.
  lcf_ram #(
    .WIDTH (SAMPLE_WIDTH),
    .DEPTH (TAPS)
  ) u_dly_ram (
    .clk   (clk),
    .we    (dly_we),
    .waddr (wp_r),
    .wdata (x_r),
    .raddr (dly_raddr),
    .rdata (dly_rdata)
  );

  assign coef_s = $signed(coef_rdata);
  assign h_s    = s1_first_r ? x_r : (s1_dval_r ? $signed(dly_rdata) : '0);
  assign prod   = coef_s * h_s;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      j_r         <= '0;
      dp_r        <= '0;
      wp_r        <= '0;
      tail_left_r <= '0;
      last_r      <= 1'b0;
      dval_r      <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Multiply-accumulate pipeline: read, multiply, accumulate.
      s1_vld_r   <= (state_r == ST_MAC);
      s1_first_r <= (j_r == '0);
      s1_last_r  <= (TCW'(j_r) == tc_m1);
      s1_dval_r  <= dval_r[dly_raddr];
      s2_vld_r   <= s1_vld_r;
      s2_first_r <= s1_first_r;
      s2_last_r  <= s1_last_r;
      s2_prod_r  <= prod;
      done_r     <= s2_vld_r && s2_last_r;
      if (s2_vld_r) begin
        acc_r <= s2_first_r ? RES_W'(s2_prod_r) : acc_r + RES_W'(s2_prod_r);
      end

      if (out_valid_r && !out_stall && !emit) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (q_valid && !q_entry.is_load) begin
            x_r         <= $signed(q_value);
            last_r      <= q_entry.last;
            tail_left_r <= q_entry.last ? tc_m1 : '0;
            j_r         <= '0;
            dp_r        <= wp_r;
            state_r     <= ST_MAC;
          end
        end
        ST_MAC: begin
          j_r <= j_r + AW'(1);
          if (j_r != '0) begin
            dp_r <= ptr_dec(dp_r);
          end
          if (TCW'(j_r) == tc_m1) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (done_r) begin
            dval_r[wp_r] <= 1'b1;
            wp_r         <= ptr_inc(wp_r);
            state_r      <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r  <= 1'b1;
            out_result_r <= acc_r;
            out_final_r  <= final_now;
            if (tail_left_r != '0) begin
              // Tail positions shift zeros through the history.
              tail_left_r <= tail_left_r - TCW'(1);
              x_r         <= '0;
              j_r         <= '0;
              dp_r        <= wp_r;
              state_r     <= ST_MAC;
            end else begin
              if (last_r) begin
                dval_r <= '0;
                wp_r   <= '0;
              end
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_result    = out_result_r;
  assign out_final_res = out_final_r;

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (state_r == ST_DRAIN))
    else $error("accumulation finished outside the drain state");

  a_tap_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MAC) |-> (TCW'(j_r) <= tc_m1))
    else $error("tap counter ran past the tap count");

  a_history_clear: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_EMIT) && slot_free && last_r && (tail_left_r == '0))
      |=> (dval_r == '0))
    else $error("history not cleared after the final output of a block");

endmodule

[rtl/core/linear_convolution_fir.sv]
// ----------------------------------------------------------------------------
// linear_convolution_fir
// Streaming full linear convolution of a Q1.15 signal with a Q1.15 kernel.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): with in_op = 0 a transaction writes
// in_value as kernel tap in_coef_index and gives no output; indexes of TAPS
// and above are ignored. With in_op = 1 it presents one signal sample; in_last
// marks the final sample of a block. Output channel (out_valid / out_stall):
// one exact Q6.30 sum per sample, and after the last sample tap_count-1 tail
// sums, the final one flagged by out_final_res. Configuration: cfg_tap_count
// sets the kernel length. The user must write it only while the block is
// idle; the block itself does not enforce this. A single multiplier handles
// one tap per cycle. A sample holds the back end through the queue pop, the
// taps in turn, the read, multiply and accumulate pipeline and the result
// hand-off; the back end pops no new command until that result is handed
// off. Each tail position follows on without a pop. A coefficient load is
// written into the coefficient RAM as it is popped.
// A two-entry command queue sits between the front and the back end, so
// inputs keep being accepted while a result waits on a stalled receiver;
// in_stall rises when the queue is full. Reset empties the queue, clears the
// sample history and sets the tap count to 16; coefficients must be loaded
// again before use.
// ----------------------------------------------------------------------------
module linear_convolution_fir import lcf_pkg::*; #(
  parameter int TAPS         = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_op,
  input  logic [IDX_W-1:0]        in_coef_index,
  input  logic [SAMPLE_WIDTH-1:0] in_value,
  input  logic                    in_last,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [RES_W-1:0]        out_result,
  output logic                    out_final_res,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [CNT_W-1:0]        cfg_tap_count
);

  logic [CNT_W-1:0]        tap_count_r;
  logic                    q_valid;
  logic                    q_pop;
  lcf_entry_t              q_entry;
  logic [SAMPLE_WIDTH-1:0] q_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_RST;
    end else if (cfg_valid && cfg_ready) begin
      tap_count_r <= cfg_tap_count;
    end
  end

  lcf_front #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_coef_index (in_coef_index),
    .in_value      (in_value),
    .in_last       (in_last),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_entry       (q_entry),
    .q_value       (q_value)
  );

  lcf_back #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .tap_count     (tap_count_r),
    .q_valid       (q_valid),
    .q_pop         (q_pop),
    .q_entry       (q_entry),
    .q_value       (q_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_result    (out_result),
    .out_final_res (out_final_res)
  );

endmodule
